FILE: src/ngfm_pkg.sv
// shared constants, types and helpers for the gga fix monitor
package ngfm_pkg;

    // sentence framing characters
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_END   = 8'h0D;  // carriage return
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    // expected talker and sentence id: G N G G A
    localparam int HEADER_LEN = 5;
    localparam logic [7:0] HEADER_TEXT [HEADER_LEN] = '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41};

    localparam int FIELD_W = 3;
    localparam int CHAR_W  = 3;
    localparam logic [FIELD_W-1:0] FIELD_MAX    = 3'd7;
    localparam logic [CHAR_W-1:0]  CHAR_MAX_POS = 3'd5;

    localparam int FIX_FIELD_INDEX_DEFAULT = 6;

    // configuration registers
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_NOFIX_LIMIT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIX_LIMIT     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NOPARSE_LIMIT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] NOFIX_LIMIT_RESET   = 8'd80;
    localparam logic [CFG_DATA_W-1:0] FIX_LIMIT_RESET     = 8'd200;
    localparam logic [CFG_DATA_W-1:0] NOPARSE_LIMIT_RESET = 8'd80;

    // alert codes
    localparam logic [1:0] ALERT_NONE      = 2'd0;
    localparam logic [1:0] ALERT_NOFIX     = 2'd1;
    localparam logic [1:0] ALERT_HEARTBEAT = 2'd2;
    localparam logic [1:0] ALERT_NOPARSE   = 2'd3;

    // what the parser reports for one byte
    typedef struct packed {
        logic done;
        logic accepted;
        logic have_fix;
    } parse_result_t;

    function automatic logic [7:0] inc_sat(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

FILE: src/ngfm_parser.sv
// byte-serial gga sentence parser holding the sentence state and the fix flag
module ngfm_parser #(
    parameter int FIX_FIELD_INDEX = ngfm_pkg::FIX_FIELD_INDEX_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    output ngfm_pkg::parse_result_t result
);

    localparam logic [ngfm_pkg::FIELD_W-1:0] FIX_FIELD = ngfm_pkg::FIELD_W'(FIX_FIELD_INDEX);

    logic                          in_sentence_reg,    in_sentence_next;
    logic [ngfm_pkg::FIELD_W-1:0]  field_number_reg,   field_number_next;
    logic [ngfm_pkg::CHAR_W-1:0]   char_in_field_reg,  char_in_field_next;
    logic                          header_match_reg,   header_match_next;
    logic                          time_present_reg,   time_present_next;
    logic                          past_star_reg,      past_star_next;
    logic                          fix_seen_reg,       fix_seen_next;
    logic                          fix_zero_reg,       fix_zero_next;
    logic                          have_fix_reg,       have_fix_next;

    logic header_open;   // still inside the first five chars of field 0
    logic header_closed; // header flag once the current field is closed
    logic done;
    logic accepted;

    assign header_open   = (field_number_reg == '0) && (char_in_field_reg < ngfm_pkg::CHAR_MAX_POS);
    assign header_closed = header_match_reg && !header_open;

    always_comb begin
        in_sentence_next   = in_sentence_reg;
        field_number_next  = field_number_reg;
        char_in_field_next = char_in_field_reg;
        header_match_next  = header_match_reg;
        time_present_next  = time_present_reg;
        past_star_next     = past_star_reg;
        fix_seen_next      = fix_seen_reg;
        fix_zero_next      = fix_zero_reg;
        have_fix_next      = have_fix_reg;
        done               = 1'b0;
        accepted           = 1'b0;

        if (rx_byte == ngfm_pkg::CH_START) begin
            in_sentence_next   = 1'b1;
            field_number_next  = '0;
            char_in_field_next = '0;
            header_match_next  = 1'b1;
            time_present_next  = 1'b0;
            past_star_next     = 1'b0;
            fix_seen_next      = 1'b0;
            fix_zero_next      = 1'b0;
        end else if (!in_sentence_reg) begin
            // outside a sentence: nothing to parse
        end else if (rx_byte == ngfm_pkg::CH_END) begin
            // cr closes the open field unless we are in the checksum
            if (!past_star_reg) begin
                header_match_next = header_closed;
            end
            done     = 1'b1;
            accepted = header_match_next && time_present_reg;
            if (accepted && fix_seen_reg) begin
                have_fix_next = !fix_zero_reg;
            end
            in_sentence_next = 1'b0;
        end else if (past_star_reg) begin
            // checksum chars are skipped
        end else if (rx_byte == ngfm_pkg::CH_COMMA || rx_byte == ngfm_pkg::CH_STAR) begin
            header_match_next = header_closed;
            if (rx_byte == ngfm_pkg::CH_STAR) begin
                past_star_next = 1'b1;
            end else if (field_number_reg >= ngfm_pkg::FIELD_MAX) begin
                char_in_field_next = ngfm_pkg::CHAR_MAX_POS;
            end else begin
                field_number_next  = field_number_reg + 1'b1;
                char_in_field_next = '0;
                if (field_number_next == FIX_FIELD) begin
                    fix_seen_next = 1'b1;
                end
            end
        end else begin
            if (header_open && (rx_byte != ngfm_pkg::HEADER_TEXT[char_in_field_reg])) begin
                header_match_next = 1'b0;
            end
            if (field_number_reg == ngfm_pkg::FIELD_W'(1)) begin
                time_present_next = 1'b1;
            end
            if ((field_number_reg == FIX_FIELD) && (char_in_field_reg == '0)
                    && (rx_byte == ngfm_pkg::CH_ZERO)) begin
                fix_zero_next = 1'b1;
            end
            if (char_in_field_reg < ngfm_pkg::CHAR_MAX_POS) begin
                char_in_field_next = char_in_field_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg   <= 1'b0;
            field_number_reg  <= '0;
            char_in_field_reg <= '0;
            header_match_reg  <= 1'b1;
            time_present_reg  <= 1'b0;
            past_star_reg     <= 1'b0;
            fix_seen_reg      <= 1'b0;
            fix_zero_reg      <= 1'b0;
            have_fix_reg      <= 1'b0;
        end else if (step) begin
            in_sentence_reg   <= in_sentence_next;
            field_number_reg  <= field_number_next;
            char_in_field_reg <= char_in_field_next;
            header_match_reg  <= header_match_next;
            time_present_reg  <= time_present_next;
            past_star_reg     <= past_star_next;
            fix_seen_reg      <= fix_seen_next;
            fix_zero_reg      <= fix_zero_next;
            have_fix_reg      <= have_fix_next;
        end
    end

    assign result.done     = done;
    assign result.accepted = accepted;
    assign result.have_fix = have_fix_next;

endmodule

FILE: src/nmea_gga_fix_monitor_top.sv
// top level of the gga fix monitor: handshake, alert counters and result register
// path: an accepted item passes through the input register, then the result register
// throughput: one item per cycle, sustained while the result side keeps taking items
// the input register refills as the result register drains, so stalls cost no bubbles
// reset (aresetn low, synchronous) empties both stages, clears the parser and counters
// and loads the limits with 80 / 200 / 80
module nmea_gga_fix_monitor_top #(
    parameter int FIX_FIELD_INDEX = ngfm_pkg::FIX_FIELD_INDEX_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // byte input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_sentence_done,
    output logic                            m_sentence_accepted,
    output logic                            m_fix_valid,
    output logic [1:0]                      m_alert,
    // limit register writes
    input  logic                            cfg_wr_en,
    input  logic [ngfm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ngfm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // limit registers
    logic [7:0] nofix_limit_reg;
    logic [7:0] fix_limit_reg;
    logic [7:0] noparse_limit_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic       out_valid_reg;
    logic       out_done_reg;
    logic       out_accepted_reg;
    logic       out_fix_reg;
    logic [1:0] out_alert_reg;

    // counters
    logic [7:0] nofix_count_reg,   nofix_count_next;
    logic [7:0] fix_count_reg,     fix_count_next;
    logic [7:0] noparse_count_reg, noparse_count_next;
    logic [1:0] alert_next;

    logic advance;  // result register can take a new item
    logic step;     // item in the input register moves on this edge

    ngfm_pkg::parse_result_t parse;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // limits are to be written only while the block is idle; the block itself does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nofix_limit_reg   <= ngfm_pkg::NOFIX_LIMIT_RESET;
            fix_limit_reg     <= ngfm_pkg::FIX_LIMIT_RESET;
            noparse_limit_reg <= ngfm_pkg::NOPARSE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ngfm_pkg::REG_NOFIX_LIMIT:   nofix_limit_reg   <= cfg_wdata;
                ngfm_pkg::REG_FIX_LIMIT:     fix_limit_reg     <= cfg_wdata;
                ngfm_pkg::REG_NOPARSE_LIMIT: noparse_limit_reg <= cfg_wdata;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    ngfm_parser #(
        .FIX_FIELD_INDEX (FIX_FIELD_INDEX)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (parse)
    );

    // counter update, then alert check against the limits
    always_comb begin
        nofix_count_next   = nofix_count_reg;
        fix_count_next     = fix_count_reg;
        noparse_count_next = ngfm_pkg::inc_sat(noparse_count_reg);
        alert_next         = ngfm_pkg::ALERT_NONE;

        if (parse.done) begin
            if (parse.accepted) begin
                noparse_count_next = '0;
                if (parse.have_fix) begin
                    fix_count_next = ngfm_pkg::inc_sat(fix_count_reg);
                end else begin
                    nofix_count_next = ngfm_pkg::inc_sat(nofix_count_reg);
                end
            end else begin
                // rejected sentence restarts the no-parse run at one
                noparse_count_next = 8'd1;
            end
        end

        // every counter past its limit clears; the first one names the alert
        if (nofix_count_next > nofix_limit_reg) begin
            nofix_count_next = '0;
            alert_next       = ngfm_pkg::ALERT_NOFIX;
        end
        if (fix_count_next > fix_limit_reg) begin
            fix_count_next = '0;
            if (alert_next == ngfm_pkg::ALERT_NONE) begin
                alert_next = ngfm_pkg::ALERT_HEARTBEAT;
            end
        end
        if (noparse_count_next > noparse_limit_reg) begin
            noparse_count_next = '0;
            if (alert_next == ngfm_pkg::ALERT_NONE) begin
                alert_next = ngfm_pkg::ALERT_NOPARSE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nofix_count_reg   <= '0;
            fix_count_reg     <= '0;
            noparse_count_reg <= '0;
        end else if (step) begin
            nofix_count_reg   <= nofix_count_next;
            fix_count_reg     <= fix_count_next;
            noparse_count_reg <= noparse_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_done_reg     <= parse.done;
            out_accepted_reg <= parse.accepted;
            out_fix_reg      <= parse.have_fix;
            out_alert_reg    <= alert_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_sentence_done     = out_done_reg;
    assign m_sentence_accepted = out_accepted_reg;
    assign m_fix_valid         = out_fix_reg;
    assign m_alert             = out_alert_reg;

endmodule

FILE: src/ngfm_checker.sv
// port-level checker for the gga fix monitor and its bind
module ngfm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_sentence_done,
    input logic       m_sentence_accepted,
    input logic       m_fix_valid,
    input logic [1:0] m_alert
);

    logic       last_fix_reg;
    logic [1:0] pending_reg;

    // fix flag of the last delivered item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_fix_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            last_fix_reg <= m_fix_valid;
        end
    end

    // items accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
        end
    end

    a_accept_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sentence_accepted |-> m_sentence_done)
        else $error("sentence accepted without sentence end");

    a_fix_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sentence_accepted |-> m_fix_valid == last_fix_reg)
        else $error("fix flag changed without an accepted sentence");

    a_pipeline_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg <= 2'd2) && (!m_valid || (pending_reg != 2'd0)))
        else $error("item count between ports out of range");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sentence_done)
            && $stable(m_sentence_accepted) && $stable(m_fix_valid) && $stable(m_alert))
        else $error("stalled result changed");

endmodule

bind nmea_gga_fix_monitor_top ngfm_checker u_ngfm_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_sentence_done     (m_sentence_done),
    .m_sentence_accepted (m_sentence_accepted),
    .m_fix_valid         (m_fix_valid),
    .m_alert             (m_alert)
);

FILE: test/nmea_gga_fix_monitor_top_tb.sv
// testbench for the gga fix monitor: directed bytes, then random sentence streams checked against a predictor
`timescale 1ns / 1ps

module nmea_gga_fix_monitor_top_tb;

    localparam int FIX_FIELD   = ngfm_pkg::FIX_FIELD_INDEX_DEFAULT;
    localparam int PHASE_BYTES = 280;  // minimum random bytes per phase, 8 phases
    localparam int N_PHASES    = 8;
    localparam int RAND_PHASE  = 5;    // this phase draws its limits at random
    localparam int DIR_LEN     = 25;

    // one result item as the block reports it
    typedef struct packed {
        logic       done;
        logic       accepted;
        logic       fix;
        logic [1:0] alert;
    } gga_result_t;

    // a directed row: the byte, and a typed-in result where one is obvious
    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        gga_result_t want;
    } dir_step_t;

    typedef struct packed {
        logic [7:0] nofix;
        logic [7:0] fix;
        logic [7:0] noparse;
    } limits_t;

    localparam gga_result_t R_IDLE      = '{1'b0, 1'b0, 1'b0, ngfm_pkg::ALERT_NONE};
    localparam gga_result_t R_ACC_NOFIX = '{1'b1, 1'b1, 1'b0, ngfm_pkg::ALERT_NONE};
    localparam gga_result_t R_REJECT    = '{1'b1, 1'b0, 1'b0, ngfm_pkg::ALERT_NONE};

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_rx_byte = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_sentence_done;
    logic                            m_sentence_accepted;
    logic                            m_fix_valid;
    logic [1:0]                      m_alert;
    logic                            cfg_wr_en = 1'b0;
    logic [ngfm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [ngfm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // expected results, oldest first
    gga_result_t gga_due_q[$];
    // bytes waiting to be sent
    logic [7:0]  stim_q[$];

    int fail_cnt     = 0;
    int src_idle_pct = 0;
    int stall_pct    = 0;
    int bytes_sent   = 0;

    // predictor copy of the limits and the block state, at reset values
    logic [7:0] lim_nofix   = ngfm_pkg::NOFIX_LIMIT_RESET;
    logic [7:0] lim_fix     = ngfm_pkg::FIX_LIMIT_RESET;
    logic [7:0] lim_noparse = ngfm_pkg::NOPARSE_LIMIT_RESET;
    logic       in_sent     = 1'b0;
    logic [2:0] fld_idx     = '0;
    logic [2:0] chr_pos     = '0;
    logic       hdr_ok      = 1'b1;
    logic       time_seen   = 1'b0;
    logic       after_star  = 1'b0;
    logic       fixfld_seen = 1'b0;
    logic       fixfld_zero = 1'b0;
    logic       have_fix    = 1'b0;
    logic [7:0] nofix_cnt   = '0;
    logic [7:0] fix_cnt     = '0;
    logic [7:0] noparse_cnt = '0;

    // directed bytes: stray bytes at the field extremes, a full no-fix sentence
    // with a checksum tail, then a sentence whose header is too short
    dir_step_t dir_steps [DIR_LEN] = '{
        '{8'h00,              1'b1, R_IDLE},       // outside a sentence, all zeros
        '{8'hFF,              1'b1, R_IDLE},       // outside a sentence, all ones
        '{ngfm_pkg::CH_END,   1'b1, R_IDLE},       // stray carriage return is ignored
        '{ngfm_pkg::CH_START, 1'b0, R_IDLE},
        '{8'h47,              1'b0, R_IDLE},       // G
        '{8'h4E,              1'b0, R_IDLE},       // N
        '{8'h47,              1'b0, R_IDLE},       // G
        '{8'h47,              1'b0, R_IDLE},       // G
        '{8'h41,              1'b0, R_IDLE},       // A
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},
        '{8'h31,              1'b0, R_IDLE},       // time field
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},       // now in the fix field
        '{ngfm_pkg::CH_ZERO,  1'b0, R_IDLE},       // fix field says no fix
        '{ngfm_pkg::CH_STAR,  1'b0, R_IDLE},
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},       // after the star, not a field split
        '{ngfm_pkg::CH_END,   1'b1, R_ACC_NOFIX},
        '{ngfm_pkg::CH_START, 1'b0, R_IDLE},
        '{8'h47,              1'b0, R_IDLE},       // G, header cut short
        '{ngfm_pkg::CH_COMMA, 1'b0, R_IDLE},
        '{8'h31,              1'b0, R_IDLE},
        '{ngfm_pkg::CH_END,   1'b1, R_REJECT}
    };

    // limits per phase; phase 0 keeps the reset values
    limits_t phase_lims [N_PHASES] = '{
        '{8'd80,  8'd200, 8'd80},
        '{8'd2,   8'd3,   8'd10},
        '{8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd255},
        '{8'd1,   8'd254, 8'd40},
        '{8'd0,   8'd0,   8'd0},
        '{8'd254, 8'd0,   8'd255},
        '{8'd4,   8'd6,   8'd25}
    };

    nmea_gga_fix_monitor_top #(
        .FIX_FIELD_INDEX(FIX_FIELD)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sentence_done    (m_sentence_done),
        .m_sentence_accepted(m_sentence_accepted),
        .m_fix_valid        (m_fix_valid),
        .m_alert            (m_alert),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // advance the parser and the alert counters by one byte
    task automatic follow_gga_byte(input logic [7:0] b, output gga_result_t r);
        logic       done;
        logic       acc;
        logic [1:0] alert;
        done  = 1'b0;
        acc   = 1'b0;
        alert = ngfm_pkg::ALERT_NONE;
        if (b == ngfm_pkg::CH_START) begin
            // a dollar sign always restarts, even mid sentence
            in_sent     = 1'b1;
            fld_idx     = '0;
            chr_pos     = '0;
            hdr_ok      = 1'b1;
            time_seen   = 1'b0;
            after_star  = 1'b0;
            fixfld_seen = 1'b0;
            fixfld_zero = 1'b0;
        end else if (!in_sent) begin
            // byte between sentences, parser untouched
        end else if (b == ngfm_pkg::CH_END) begin
            // the carriage return closes the last field
            if (!after_star && fld_idx == 0 && chr_pos < ngfm_pkg::CHAR_MAX_POS)
                hdr_ok = 1'b0;
            done = 1'b1;
            acc  = hdr_ok && time_seen;
            if (acc && fixfld_seen)
                have_fix = !fixfld_zero;
            in_sent = 1'b0;
        end else if (after_star) begin
            // checksum tail, ignored until the carriage return
        end else if (b == ngfm_pkg::CH_COMMA || b == ngfm_pkg::CH_STAR) begin
            if (fld_idx == 0 && chr_pos < ngfm_pkg::CHAR_MAX_POS)
                hdr_ok = 1'b0;
            if (b == ngfm_pkg::CH_STAR) begin
                after_star = 1'b1;
            end else if (fld_idx >= ngfm_pkg::FIELD_MAX) begin
                chr_pos = ngfm_pkg::CHAR_MAX_POS;
            end else begin
                fld_idx = fld_idx + 3'd1;
                chr_pos = '0;
                if (fld_idx == FIX_FIELD)
                    fixfld_seen = 1'b1;
            end
        end else begin
            if (fld_idx == 0 && chr_pos < ngfm_pkg::CHAR_MAX_POS
                    && b != ngfm_pkg::HEADER_TEXT[chr_pos])
                hdr_ok = 1'b0;
            if (fld_idx == 1)
                time_seen = 1'b1;
            if (fld_idx == FIX_FIELD && chr_pos == 0 && b == ngfm_pkg::CH_ZERO)
                fixfld_zero = 1'b1;
            if (chr_pos < ngfm_pkg::CHAR_MAX_POS)
                chr_pos = chr_pos + 3'd1;
        end

        // counters saturate at 255
        if (done) begin
            noparse_cnt = '0;
            if (acc && have_fix)
                fix_cnt = (fix_cnt == 8'hFF) ? fix_cnt : fix_cnt + 8'd1;
            else if (acc)
                nofix_cnt = (nofix_cnt == 8'hFF) ? nofix_cnt : nofix_cnt + 8'd1;
            else
                noparse_cnt = 8'd1;
        end else begin
            noparse_cnt = (noparse_cnt == 8'hFF) ? noparse_cnt : noparse_cnt + 8'd1;
        end

        // all counters over their limit clear; the first one names the alert
        if (nofix_cnt > lim_nofix) begin
            nofix_cnt = '0;
            alert     = ngfm_pkg::ALERT_NOFIX;
        end
        if (fix_cnt > lim_fix) begin
            fix_cnt = '0;
            if (alert == ngfm_pkg::ALERT_NONE)
                alert = ngfm_pkg::ALERT_HEARTBEAT;
        end
        if (noparse_cnt > lim_noparse) begin
            noparse_cnt = '0;
            if (alert == ngfm_pkg::ALERT_NONE)
                alert = ngfm_pkg::ALERT_NOPARSE;
        end
        r = '{done, acc, have_fix, alert};
    endtask

    // a character that is neither framing nor a separator
    function automatic logic [7:0] pick_field_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 3) == 0)
                c = 8'h41 + 8'($urandom_range(0, 25));  // capital letter
            else
                c = ngfm_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        end else begin
            do
                c = 8'($urandom_range(0, 255));
            while (c inside {ngfm_pkg::CH_START, ngfm_pkg::CH_END,
                             ngfm_pkg::CH_COMMA, ngfm_pkg::CH_STAR});
        end
        return c;
    endfunction

    // one gga-like sentence; a broken one is cut off before its end
    task automatic queue_sentence(input bit broken);
        logic [7:0] s[$];
        logic [7:0] c;
        int nf;
        int n;
        s.push_back(ngfm_pkg::CH_START);
        case ($urandom_range(0, 9))
            0: begin
                // header shorter than five characters
                n = $urandom_range(0, ngfm_pkg::HEADER_LEN - 1);
                for (int i = 0; i < n; i++)
                    s.push_back(ngfm_pkg::HEADER_TEXT[i]);
            end
            1: begin
                for (int i = 0; i < ngfm_pkg::HEADER_LEN; i++)
                    s.push_back(ngfm_pkg::HEADER_TEXT[i]);
                s[1 + $urandom_range(0, ngfm_pkg::HEADER_LEN - 1)] = pick_field_char();
            end
            2: begin
                n = $urandom_range(1, 7);
                repeat (n) s.push_back(pick_field_char());
            end
            default: begin
                for (int i = 0; i < ngfm_pkg::HEADER_LEN; i++)
                    s.push_back(ngfm_pkg::HEADER_TEXT[i]);
                if ($urandom_range(0, 3) == 0)
                    s.push_back(pick_field_char());
            end
        endcase

        // mostly long enough to reach the fix field, sometimes past field seven
        nf = ($urandom_range(0, 9) < 7) ? $urandom_range(6, 10) : $urandom_range(0, 5);
        for (int f = 1; f <= nf; f++) begin
            s.push_back(ngfm_pkg::CH_COMMA);
            if (f == 1) begin
                n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : 0;
            end else if (f == FIX_FIELD) begin
                case ($urandom_range(0, 4))
                    0, 1: s.push_back(ngfm_pkg::CH_ZERO);
                    2, 3: s.push_back(ngfm_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
                    default: ;
                endcase
                n = $urandom_range(0, 2);
            end else begin
                n = $urandom_range(0, 4);
            end
            repeat (n) s.push_back(pick_field_char());
        end

        // checksum tail may hold commas and anything but framing
        if ($urandom_range(0, 2) == 0) begin
            s.push_back(ngfm_pkg::CH_STAR);
            n = $urandom_range(0, 3);
            repeat (n) begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == ngfm_pkg::CH_START || c == ngfm_pkg::CH_END);
                s.push_back(c);
            end
        end
        s.push_back(ngfm_pkg::CH_END);

        if (broken) begin
            n = $urandom_range(1, s.size() - 1);
            s = s[0:n-1];
        end
        stim_q = {stim_q, s};
    endtask

    // offer one item, wait for the handshake, then record what should come back
    task automatic send_byte(input logic [7:0] b, input logic typed, input gga_result_t want);
        gga_result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        follow_gga_byte(b, r);
        gga_due_q.push_back(typed ? want : r);
        bytes_sent++;
    endtask

    task automatic write_limit(input logic [ngfm_pkg::CFG_ADDR_W-1:0] idx,
                               input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            ngfm_pkg::REG_NOFIX_LIMIT: lim_nofix   = val;
            ngfm_pkg::REG_FIX_LIMIT:   lim_fix     = val;
            default:                   lim_noparse = val;
        endcase
    endtask

    // stop sending and let every outstanding result drain
    task automatic settle();
        s_valid <= 1'b0;
        while (gga_due_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // result side stalls at random per phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare every accepted result item with the oldest expectation
    always @(posedge aclk) begin : result_check
        gga_result_t got;
        gga_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_sentence_done, m_sentence_accepted, m_fix_valid, m_alert};
            if (gga_due_q.size() == 0) begin
                $display("%0t: result with nothing expected, got %b", $time, got);
                fail_cnt++;
            end else begin
                want = gga_due_q.pop_front();
                check_field("sentence_done", want.done, got.done);
                check_field("sentence_accepted", want.accepted, got.accepted);
                check_field("fix_valid", want.fix, got.fix);
                check_field("alert", want.alert, got.alert);
            end
        end
    end

    // stimulus: reset, directed rows, then phases of random sentences
    initial begin
        limits_t    lims;
        int         r;
        int         n;
        logic [7:0] b;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part runs with reset limits and no idling
        for (int i = 0; i < DIR_LEN; i++)
            send_byte(dir_steps[i].rx, dir_steps[i].typed, dir_steps[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                // limits change only with nothing in flight
                settle();
                lims = phase_lims[ph];
                if (ph == RAND_PHASE)
                    lims = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255))};
                write_limit(ngfm_pkg::REG_NOFIX_LIMIT, lims.nofix);
                write_limit(ngfm_pkg::REG_FIX_LIMIT, lims.fix);
                write_limit(ngfm_pkg::REG_NOPARSE_LIMIT, lims.noparse);
                cfg_wr_en <= 1'b0;
            end
            case (ph % 4)
                0: begin
                    src_idle_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    src_idle_pct = 55;
                    stall_pct    = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    stall_pct    = 55;
                end
                default: begin
                    src_idle_pct = 28;
                    stall_pct    = 28;
                end
            endcase

            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                // mostly whole sentences, some cut short, some raw noise
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    queue_sentence(1'b0);
                end else if (r < 88) begin
                    queue_sentence(1'b1);
                end else begin
                    // long noise runs let the no-parse counter reach its limit
                    n = (r < 95) ? $urandom_range(1, 12) : $urandom_range(60, 120);
                    repeat (n) stim_q.push_back(8'($urandom_range(0, 255)));
                end
                while (stim_q.size() != 0) begin
                    b = stim_q.pop_front();
                    send_byte(b, 1'b0, R_IDLE);
                end
            end
        end

        settle();
        repeat (6) @(posedge aclk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
